// ----- rtl/sacl_pkg.sv -----
// Package for the set-associative FIFO cache lookup: sizes, derived address
// split, state machine encoding and the controller/datapath interface types.
// No dependencies.
`default_nettype none

package sacl_pkg;

  localparam int WORDS_PER_BLOCK = 4;
  localparam int SET_COUNT       = 64;
  localparam int WAYS            = 4;
  localparam int BYTES_PER_WORD  = 4;

  localparam int ADDR_W = 32;
  localparam int CNT_W  = 32;

  function automatic int floor_log2(input int v);
    int n;
    int x;
    n = 0;
    x = v;
    while (x > 1) begin
      x = x >> 1;
      n = n + 1;
    end
    return n;
  endfunction

  // address split: byte offset, set index, tag
  localparam int OFF_W    = floor_log2(WORDS_PER_BLOCK * BYTES_PER_WORD);
  localparam int SET_BITS = floor_log2(SET_COUNT);
  localparam int TAG_W    = ADDR_W - OFF_W - SET_BITS;

  localparam logic [ADDR_W-1:0] SET_MASK = ADDR_W'((64'd1 << SET_BITS) - 64'd1);

  localparam int IDX_W  = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
  localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int FILL_W = $clog2(WAYS + 1);

  localparam int OUT_W       = 1 + 2 * CNT_W;
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_LOOKUP
  } state_t;

  typedef struct packed {
    logic load;    // request taken: register address, read set
    logic commit;  // compare result used: update set, counters, output
  } dp_cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] hits;
    logic [CNT_W-1:0] misses;
  } dp_stat_t;

  typedef struct packed {
    logic [FILL_W-1:0] filled;
    logic [WAY_W-1:0]  oldest;
  } meta_t;

endpackage

`default_nettype wire

// ----- rtl/sacl_ctrl.sv -----
// Controller for the cache lookup: two-state sequencer and output valid flag.
// Depends on sacl_pkg.
`default_nettype none

module sacl_ctrl
  import sacl_pkg::*;
(
  input  wire     clk,
  input  wire     rst,
  input  wire     s_tvalid,
  output logic    s_tready,
  output logic    m_tvalid,
  input  wire     m_tready,
  output dp_cmd_t cmd
);

  state_t state;
  state_t state_next;
  logic   out_valid;
  logic   slot_free;

  assign slot_free = !out_valid || m_tready;
  assign m_tvalid  = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        if (slot_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready   = 1'b0;
    cmd.load   = 1'b0;
    cmd.commit = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
      end
      ST_LOOKUP: begin
        // hold the lookup until the output register can take the result
        cmd.commit = slot_free;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/sacl_datapath.sv -----
// Datapath for the cache lookup: tag and set-state memories, way compare,
// FIFO replacement, hit/miss counters and the output register.
// Depends on sacl_pkg.
`default_nettype none

module sacl_datapath
  import sacl_pkg::*;
(
  input  wire                     clk,
  input  wire                     rst,
  input  dp_cmd_t                 cmd,
  input  wire  [ADDR_W-1:0]       s_tdata,
  output logic [OUT_TDATA_W-1:0]  m_tdata,
  output dp_stat_t                stat
);

  // per-set tag rows and fill/oldest state
  logic [TAG_W-1:0] tag_mem  [SET_COUNT][WAYS];
  meta_t            meta_mem [SET_COUNT];
  logic             meta_vld [SET_COUNT];

  logic [IDX_W-1:0] rd_idx;
  logic [TAG_W-1:0] rd_tag;

  logic [IDX_W-1:0] set_q;
  logic [TAG_W-1:0] tag_q;
  logic [TAG_W-1:0] row_q [WAYS];
  meta_t            meta_q;
  logic             vld_q;

  logic [CNT_W-1:0] hit_cnt;
  logic [CNT_W-1:0] miss_cnt;
  logic [CNT_W-1:0] hit_cnt_next;
  logic [CNT_W-1:0] miss_cnt_next;

  logic [FILL_W-1:0] filled;
  logic [WAY_W-1:0]  oldest;
  logic              hit;
  logic [WAY_W-1:0]  wr_way;
  meta_t             meta_new;

  assign rd_idx = IDX_W'((s_tdata >> OFF_W) & SET_MASK);
  assign rd_tag = TAG_W'(s_tdata >> (OFF_W + SET_BITS));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      set_q  <= rd_idx;
      tag_q  <= rd_tag;
      row_q  <= tag_mem[rd_idx];
      meta_q <= meta_mem[rd_idx];
      vld_q  <= meta_vld[rd_idx];
    end
  end

  // a set never written reads as empty
  assign filled = vld_q ? meta_q.filled : '0;
  assign oldest = vld_q ? meta_q.oldest : '0;

  always_comb begin
    hit = 1'b0;
    for (int w = 0; w < WAYS; w++) begin
      if ((FILL_W'(w) < filled) && (row_q[w] == tag_q)) hit = 1'b1;
    end
  end

  always_comb begin
    meta_new.filled = filled;
    meta_new.oldest = oldest;
    if (filled < FILL_W'(WAYS)) begin
      wr_way          = WAY_W'(filled);
      meta_new.filled = filled + FILL_W'(1);
    end else begin
      wr_way = oldest;
      if (oldest == WAY_W'(WAYS - 1)) begin
        meta_new.oldest = '0;
      end else begin
        meta_new.oldest = oldest + WAY_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && !hit) begin
      tag_mem[set_q][wr_way] <= tag_q;
      meta_mem[set_q]        <= meta_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < SET_COUNT; s++) meta_vld[s] <= 1'b0;
    end else if (cmd.commit && !hit) begin
      meta_vld[set_q] <= 1'b1;
    end
  end

  assign hit_cnt_next  = hit ? hit_cnt + CNT_W'(1) : hit_cnt;
  assign miss_cnt_next = hit ? miss_cnt : miss_cnt + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_cnt  <= '0;
      miss_cnt <= '0;
    end else if (cmd.commit) begin
      hit_cnt  <= hit_cnt_next;
      miss_cnt <= miss_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      m_tdata <= {{(OUT_TDATA_W - OUT_W){1'b0}}, miss_cnt_next, hit_cnt_next, hit};
    end
  end

  assign stat.hits   = hit_cnt;
  assign stat.misses = miss_cnt;

endmodule

`default_nettype wire

// ----- rtl/set_assoc_fifo_cache_lookup.sv -----
// Set-associative tag lookup with FIFO replacement. Each request carries a
// byte address; the result gives hit/miss and both running counters. When
// a request is taken, the set's tag row and fill state are read from their
// memories into registers; the lookup state then compares all ways and, on
// a miss, writes the set back. The lookup waits there until the output
// register can take the result, and a new request is taken only after that,
// so one request is in flight at a time. All sets are empty straight out of
// reset (per-set valid flops), so no clearing pass is needed.
// Depends on sacl_pkg, sacl_ctrl and sacl_datapath.
`default_nettype none

module set_assoc_fifo_cache_lookup
  import sacl_pkg::*;
(
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     s_tvalid,
  output logic                    s_tready,
  input  wire  [ADDR_W-1:0]       s_tdata,   // [31:0] address
  output logic                    m_tvalid,
  input  wire                     m_tready,
  output logic [OUT_TDATA_W-1:0]  m_tdata    // [0] was_hit, [32:1] hits_so_far,
                                             // [64:33] misses_so_far, rest zero
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  sacl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  sacl_datapath u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .s_tdata (s_tdata),
    .m_tdata (m_tdata),
    .stat    (stat)
  );

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("request taken while a lookup is in progress");

  a_commit_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> m_tvalid)
    else $error("result not presented after commit");

  a_out_matches_cnt: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> (m_tdata[CNT_W:1] == stat.hits) &&
                   (m_tdata[2*CNT_W:CNT_W+1] == stat.misses))
    else $error("output counters differ from internal counters");

  a_one_count_step: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> CNT_W'(stat.hits + stat.misses) ==
                   CNT_W'($past(stat.hits) + $past(stat.misses) + CNT_W'(1)))
    else $error("counters did not advance by exactly one");

endmodule

`default_nettype wire
